[hw/rtl/damped_feedback_comb_filter_defines.svh]
// Assertion macros used by the comb filter top module.
`ifndef DAMPED_FEEDBACK_COMB_FILTER_DEFINES_SVH
`define DAMPED_FEEDBACK_COMB_FILTER_DEFINES_SVH
`ifndef ASSERT_OFF
`define DFCF_ASSERT(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("dfcf assertion failed");
`define DFCF_NEVER(label, clk, rst_n, expr) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
		else $error("dfcf forbidden condition");
`else
`define DFCF_ASSERT(label, clk, rst_n, prop)
`define DFCF_NEVER(label, clk, rst_n, expr)
`endif
`endif

[hw/rtl/dfcf_pkg.sv]
`default_nettype none
package dfcf_pkg;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 28;

	localparam logic [CFG_IDX_W-1:0] REG_DELAY_TARGET  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SLEW_COEF     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_FEEDBACK_GAIN = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_DAMPING_COEF  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_PHASE_COMP    = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_WET_MIX       = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_GAIN   = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_DELAY     = 3'd7;

	localparam logic [23:0] ONE_Q23 = 24'h800000;

	typedef struct packed {
		logic [27:0] delay_target;
		logic [23:0] slew_coef;
		logic [23:0] feedback_gain;
		logic [23:0] damping_coef;
		logic [27:0] phase_comp;
		logic [23:0] wet_mix;
		logic [23:0] output_gain;
		logic [27:0] min_delay;
	} cfg_t;

	typedef enum logic [4:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_SLEW,
		ST_DELAY,
		ST_RD0,
		ST_RD1,
		ST_RD2,
		ST_RD3,
		ST_H1,
		ST_H2,
		ST_H3,
		ST_H4,
		ST_H5,
		ST_H6,
		ST_D1,
		ST_D2,
		ST_F1,
		ST_F2,
		ST_M1,
		ST_M2,
		ST_M3,
		ST_M4,
		ST_FIN,
		ST_PASS
	} st_t;

endpackage
`default_nettype wire

[hw/rtl/dfcf_in_if.sv]
`default_nettype none
interface dfcf_in_if #(
	parameter int SAMPLE_BITS = 24
);
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] sample_in;
	logic                          channel;

	modport source(output valid, output sample_in, output channel, input ready);
	modport sink(input valid, input sample_in, input channel, output ready);
endinterface
`default_nettype wire

[hw/rtl/dfcf_out_if.sv]
`default_nettype none
interface dfcf_out_if #(
	parameter int SAMPLE_BITS = 24
);
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] sample_out;

	modport source(output valid, output sample_out, input ready);
	modport sink(input valid, input sample_out, output ready);
endinterface
`default_nettype wire

[hw/rtl/dfcf_cfg_if.sv]
`default_nettype none
interface dfcf_cfg_if;
	import dfcf_pkg::*;

	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source(output valid, output index, output data, input ready);
	modport sink(input valid, input index, input data, output ready);
endinterface
`default_nettype wire

[hw/rtl/damped_feedback_comb_filter.sv]
// Damped feedback comb filter. Each input transaction carries one sample and a channel number;
// the block answers with exactly one output transaction. It takes no new sample before the last
// one has finished, a limit set by the single-port delay store (four tap reads and one write)
// and the one shared multiplier that steps through every product of the sample in turn. A finished
// result waits in the output register while the next sample is taken. After reset the block runs
// a clearing pass over the whole delay store, all CHANNELS * DELAY_FRAMES words (8192 at the
// defaults), and accepts no sample until it ends; configuration writes are taken at any time
// but must only be issued while no sample is in flight. A channel number at or above CHANNELS
// passes the sample through unchanged. DELAY_FRAMES must be a power of two.
`default_nettype none
`include "damped_feedback_comb_filter_defines.svh"
module damped_feedback_comb_filter #(
	parameter int DELAY_FRAMES = 4096,
	parameter int CHANNELS     = 2,
	parameter int SAMPLE_BITS  = 24
) (
	input  logic      clk,
	input  logic      arst_n,
	dfcf_in_if.sink   in_ch,
	dfcf_out_if.source out_ch,
	dfcf_cfg_if.sink  cfg
);
	import dfcf_pkg::*;

	localparam int SB  = SAMPLE_BITS;
	localparam int AB  = $clog2(DELAY_FRAMES);
	localparam int MD  = CHANNELS * DELAY_FRAMES;
	localparam int MAW = $clog2(MD);
	localparam int CIW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int DW  = SB + 7;
	localparam int MW  = DW + 3;
	localparam int EW  = ((DW > 32) ? DW : 32) + 1;
	localparam int AWD = (EW > SB + 10) ? EW : SB + 10;
	localparam int PW  = AWD + 25;

	localparam logic signed [PW-1:0] RND23  = PW'(64'sd4194304);
	localparam logic signed [PW-1:0] RND20  = PW'(64'sd524288);
	localparam logic signed [PW-1:0] RND17  = PW'(64'sd65536);
	localparam logic signed [PW-1:0] SAT_HI = PW'((64'sd1 <<< (SB - 1)) - 64'sd1);
	localparam logic signed [PW-1:0] SAT_LO = -SAT_HI - PW'(64'sd1);
	localparam logic signed [EW:0]   D_HI   = (EW+1)'(64'sd2147483647);
	localparam logic signed [EW:0]   D_LO   = (EW+1)'(-64'sd2147483648);
	localparam logic signed [33:0]   DMAX   = 34'(longint'(DELAY_FRAMES - 4) * 64'sd65536);

	cfg_t cfg_regs;

	dfcf_cfg_regs u_cfg_regs (
		.clk   (clk),
		.arst_n(arst_n),
		.cfg   (cfg),
		.regs  (cfg_regs)
	);

	st_t state_q, state_d;

	logic [MAW-1:0]          clr_q;
	logic signed [SB-1:0]    x_q;
	logic [CIW-1:0]          ch_q;
	logic [27:0]             cur_q [CHANNELS];
	logic signed [31:0]      damp_q [CHANNELS];
	logic [AB-1:0]           widx_q [CHANNELS];
	logic signed [SB-1:0]    store_mem [MD];
	logic signed [SB-1:0]    rd_q;
	logic [AB-1:0]           base_q;
	logic [15:0]             t_q;
	logic signed [SB-1:0]    y0_q, y1_q, y2_q;
	logic signed [PW-1:0]    p_q;
	logic signed [SB+5:0]    a_q;
	logic signed [DW-1:0]    dly_q;
	logic signed [31:0]      dmp_q;
	logic signed [MW-1:0]    mix_q;
	logic                    out_valid_q;
	logic signed [SB-1:0]    out_data_q;

	logic                    mem_we, mem_re, out_free, out_load, ch_absent;
	logic [MAW-1:0]          mem_waddr, mem_raddr;
	logic signed [SB-1:0]    mem_wdata, res;
	logic [AB-1:0]           tap_idx;
	logic signed [AWD-1:0]   mul_a;
	logic signed [24:0]      mul_b;
	logic signed [PW-1:0]    mul_p, res_full, fsum_ext;
	logic [23:0]             slew_l, damp_l, wet_l;
	logic [27:0]             cur_now, cur_cl;
	logic signed [31:0]      dmp_cur, dmp_sat;
	logic [AB-1:0]           widx_now;
	logic signed [28:0]      diff;
	logic signed [30:0]      cur_sum;
	logic signed [29:0]      d_raw;
	logic signed [33:0]      d_ext, min_ext, d_cl;
	logic [AB+15:0]          pos;
	logic signed [16:0]      t_s;
	logic signed [SB:0]      c1;
	logic signed [SB+3:0]    c2;
	logic signed [SB+2:0]    c3;
	logic signed [EW:0]      dsum;
	logic signed [33:0]      fsum;

	assign slew_l = (cfg_regs.slew_coef > ONE_Q23) ? ONE_Q23 : cfg_regs.slew_coef;
	assign damp_l = (cfg_regs.damping_coef > ONE_Q23) ? ONE_Q23 : cfg_regs.damping_coef;
	assign wet_l  = (cfg_regs.wet_mix > ONE_Q23) ? ONE_Q23 : cfg_regs.wet_mix;

	assign cur_now  = cur_q[ch_q];
	assign dmp_cur  = damp_q[ch_q];
	assign widx_now = widx_q[ch_q];

	assign diff    = $signed({1'b0, cfg_regs.delay_target}) - $signed({1'b0, cur_now});
	assign cur_sum = $signed({3'b000, cur_now}) + 31'((p_q + RND23) >>> 23);
	assign cur_cl  = (cur_sum < 31'sd0) ? 28'd0 :
		(cur_sum > 31'sd268435455) ? 28'hFFFFFFF : cur_sum[27:0];
	assign d_raw   = $signed({2'b00, cur_cl}) - $signed({2'b00, cfg_regs.phase_comp});
	assign d_ext   = 34'(d_raw);
	assign min_ext = $signed({6'b000000, cfg_regs.min_delay});
	assign d_cl    = (d_ext < min_ext) ? min_ext : ((d_ext > DMAX) ? DMAX : d_ext);
	assign pos     = {widx_now, 16'h0000} - (AB+16)'(d_cl);

	assign t_s = $signed({1'b0, t_q});
	assign c1  = y2_q - y0_q;
	assign c2  = (SB+4)'(2 * y0_q - 5 * y1_q + 4 * y2_q - rd_q);
	assign c3  = (SB+3)'((rd_q - y0_q) + 3 * (y1_q - y2_q));

	assign dsum    = (EW+1)'(dmp_cur) + (EW+1)'((p_q + RND23) >>> 23);
	assign dmp_sat = (dsum > D_HI) ? 32'sh7FFFFFFF : ((dsum < D_LO) ? 32'sh80000000 : 32'(dsum));

	assign fsum     = 34'(x_q) + 34'((p_q + RND23) >>> 23);
	assign fsum_ext = PW'(fsum);
	assign res_full = (p_q + RND20) >>> 20;
	assign res      = (res_full > SAT_HI) ? SB'(SAT_HI) :
		((res_full < SAT_LO) ? SB'(SAT_LO) : SB'(res_full));

	assign mul_p = mul_a * mul_b;

	assign ch_absent = 32'(in_ch.channel) >= CHANNELS;
	assign out_free  = !out_valid_q || out_ch.ready;

	assign in_ch.ready       = (state_q == ST_IDLE);
	assign out_ch.valid      = out_valid_q;
	assign out_ch.sample_out = out_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		mem_we    = 1'b0;
		mem_re    = 1'b0;
		mem_wdata = '0;
		tap_idx   = base_q;
		mul_a     = '0;
		mul_b     = '0;
		out_load  = 1'b0;
		mem_waddr = clr_q;
		unique case (state_q)
			ST_CLEAR: begin
				mem_we = 1'b1;
				if (clr_q == MAW'(MD - 1)) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (in_ch.valid) state_d = ch_absent ? ST_PASS : ST_SLEW;
			end
			ST_SLEW: begin
				mul_a   = AWD'(diff);
				mul_b   = $signed({1'b0, slew_l});
				state_d = ST_DELAY;
			end
			ST_DELAY: state_d = ST_RD0;
			ST_RD0: begin
				mem_re  = 1'b1;
				tap_idx = base_q - AB'(1);
				state_d = ST_RD1;
			end
			ST_RD1: begin
				mem_re  = 1'b1;
				tap_idx = base_q;
				state_d = ST_RD2;
			end
			ST_RD2: begin
				mem_re  = 1'b1;
				tap_idx = base_q + AB'(1);
				state_d = ST_RD3;
			end
			ST_RD3: begin
				mem_re  = 1'b1;
				tap_idx = base_q + AB'(2);
				state_d = ST_H1;
			end
			ST_H1: begin
				mul_a   = AWD'(c3);
				mul_b   = 25'(t_s);
				state_d = ST_H2;
			end
			ST_H2: state_d = ST_H3;
			ST_H3: begin
				mul_a   = AWD'(a_q);
				mul_b   = 25'(t_s);
				state_d = ST_H4;
			end
			ST_H4: state_d = ST_H5;
			ST_H5: begin
				mul_a   = AWD'(a_q);
				mul_b   = 25'(t_s);
				state_d = ST_H6;
			end
			ST_H6: state_d = ST_D1;
			ST_D1: begin
				mul_a   = AWD'(dly_q) - AWD'(dmp_cur);
				mul_b   = $signed({1'b0, damp_l});
				state_d = ST_D2;
			end
			ST_D2: state_d = ST_F1;
			ST_F1: begin
				mul_a   = AWD'(dmp_q);
				mul_b   = 25'($signed(cfg_regs.feedback_gain));
				state_d = ST_F2;
			end
			ST_F2: begin
				mem_we    = 1'b1;
				mem_waddr = (MAW'(ch_q) << AB) | MAW'(widx_now);
				mem_wdata = (fsum_ext > SAT_HI) ? SB'(SAT_HI) :
					((fsum_ext < SAT_LO) ? SB'(SAT_LO) : SB'(fsum));
				state_d   = ST_M1;
			end
			ST_M1: begin
				mul_a   = AWD'(x_q);
				mul_b   = $signed({1'b0, ONE_Q23 - wet_l});
				state_d = ST_M2;
			end
			ST_M2: begin
				mul_a   = AWD'(dly_q);
				mul_b   = $signed({1'b0, wet_l});
				state_d = ST_M3;
			end
			ST_M3: state_d = ST_M4;
			ST_M4: begin
				mul_a   = AWD'(mix_q);
				mul_b   = $signed({1'b0, cfg_regs.output_gain});
				state_d = ST_FIN;
			end
			ST_FIN, ST_PASS: begin
				if (out_free) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_CLEAR;
		endcase
	end

	assign mem_raddr = (MAW'(ch_q) << AB) | MAW'(tap_idx);

	always_ff @(posedge clk) begin
		if (mem_we) store_mem[mem_waddr] <= mem_wdata;
		if (mem_re) rd_q <= store_mem[mem_raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q       <= '0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < CHANNELS; i++) begin
				cur_q[i]  <= '0;
				damp_q[i] <= '0;
				widx_q[i] <= '0;
			end
		end else begin
			if (state_q == ST_CLEAR) clr_q <= clr_q + MAW'(1);
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
			if (state_q == ST_DELAY) cur_q[ch_q] <= cur_cl;
			if (state_q == ST_D2) damp_q[ch_q] <= dmp_sat;
			if (state_q == ST_F2) widx_q[ch_q] <= widx_now + AB'(1);
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				x_q  <= in_ch.sample_in;
				ch_q <= CIW'(in_ch.channel);
			end
			ST_SLEW, ST_H1, ST_H3, ST_H5, ST_D1, ST_F1, ST_M1, ST_M4: p_q <= mul_p;
			ST_DELAY: begin
				base_q <= pos[AB+15:16];
				t_q    <= pos[15:0];
			end
			ST_RD1: y0_q <= rd_q;
			ST_RD2: y1_q <= rd_q;
			ST_RD3: y2_q <= rd_q;
			ST_H2: a_q <= (SB+6)'(p_q >>> 16) + (SB+6)'(c2);
			ST_H4: a_q <= (SB+6)'(p_q >>> 16) + (SB+6)'(c1);
			ST_H6: dly_q <= DW'((p_q + RND17) >>> 17) + DW'(y1_q);
			ST_D2: dmp_q <= dmp_sat;
			ST_M2: p_q <= p_q + mul_p;
			ST_M3: mix_q <= MW'((p_q + RND23) >>> 23);
			ST_FIN: begin
				if (out_free) out_data_q <= res;
			end
			ST_PASS: begin
				if (out_free) out_data_q <= x_q;
			end
			default: ;
		endcase
	end

	`DFCF_ASSERT(a_load_shows, clk, arst_n, out_load |=> out_ch.valid)
	`DFCF_NEVER(a_port_conflict, clk, arst_n, mem_we && mem_re)
	`DFCF_ASSERT(a_widx_step, clk, arst_n,
		state_q == ST_F2 |=> widx_q[$past(ch_q)] == $past(widx_now) + AB'(1))
	`DFCF_ASSERT(a_clear_blocks, clk, arst_n, state_q == ST_CLEAR |-> !in_ch.ready && !out_ch.valid)

endmodule
`default_nettype wire

[hw/rtl/dfcf_cfg_regs.sv]
`default_nettype none
module dfcf_cfg_regs (
	input  logic           clk,
	input  logic           arst_n,
	dfcf_cfg_if.sink       cfg,
	output dfcf_pkg::cfg_t regs
);
	import dfcf_pkg::*;

	cfg_t regs_q;

	assign cfg.ready = 1'b1;
	assign regs      = regs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.delay_target  <= 28'd31457280;
			regs_q.slew_coef     <= ONE_Q23;
			regs_q.feedback_gain <= 24'd0;
			regs_q.damping_coef  <= ONE_Q23;
			regs_q.phase_comp    <= 28'd0;
			regs_q.wet_mix       <= ONE_Q23;
			regs_q.output_gain   <= 24'd1048576;
			regs_q.min_delay     <= 28'd196608;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				REG_DELAY_TARGET:  regs_q.delay_target  <= cfg.data;
				REG_SLEW_COEF:     regs_q.slew_coef     <= cfg.data[23:0];
				REG_FEEDBACK_GAIN: regs_q.feedback_gain <= cfg.data[23:0];
				REG_DAMPING_COEF:  regs_q.damping_coef  <= cfg.data[23:0];
				REG_PHASE_COMP:    regs_q.phase_comp    <= cfg.data;
				REG_WET_MIX:       regs_q.wet_mix       <= cfg.data[23:0];
				REG_OUTPUT_GAIN:   regs_q.output_gain   <= cfg.data[23:0];
				REG_MIN_DELAY:     regs_q.min_delay     <= cfg.data;
				default:           regs_q <= regs_q;
			endcase
		end
	end
endmodule
`default_nettype wire
